### hw/rtl/vertex_triple_deduplicator_macros.svh
// Assertion macros shared by the vertex triple deduplicator RTL.
`ifndef VERTEX_TRIPLE_DEDUPLICATOR_MACROS_SVH
`define VERTEX_TRIPLE_DEDUPLICATOR_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define VTD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define VTD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/vtd_pkg.sv
// Types, constants and state codes of the vertex triple deduplicator.
package vtd_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int ADDR_BITS     = $clog2(TABLE_ENTRIES);
    localparam int FILL_BITS     = $clog2(TABLE_ENTRIES + 1);
    localparam int REF_BITS      = 24;
    localparam int COUNT_BITS    = 23;
    localparam int INDEX_BITS    = 12;
    localparam int CFG_IDX_BITS  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_POSITION_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NORMAL_COUNT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TEXCOORD_COUNT = 2'd2;

    // One stored reference triple.
    typedef struct packed {
        logic [REF_BITS-1:0] texcoord_key;
        logic [REF_BITS-1:0] normal_key;
        logic [REF_BITS-1:0] position_key;
    } key_t;

    // Input word, last declared field in the lowest bits.
    typedef struct packed {
        logic signed [REF_BITS-1:0] texcoord_ref;
        logic signed [REF_BITS-1:0] normal_ref;
        logic signed [REF_BITS-1:0] position_ref;
        logic                       clear_first;
    } in_word_t;

    // Result word, last declared field in the lowest bits.
    typedef struct packed {
        logic                    slot_out_of_range;
        logic [COUNT_BITS-1:0]   texcoord_slot;
        logic                    texcoord_present;
        logic [COUNT_BITS-1:0]   normal_slot;
        logic                    normal_present;
        logic [COUNT_BITS-1:0]   position_slot;
        logic                    table_full;
        logic                    is_new;
        logic [INDEX_BITS-1:0]   vertex_index;
    } result_t;

    localparam int IN_WORD_BITS   = $bits(in_word_t);
    localparam int IN_TDATA_BITS  = ((IN_WORD_BITS + 7) / 8) * 8;
    localparam int OUT_WORD_BITS  = $bits(result_t);
    localparam int OUT_TDATA_BITS = ((OUT_WORD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_WORD_BITS;

    // Key memory command from the sequencer.
    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        key_t                 wdata;
        logic                 re;
        logic [ADDR_BITS-1:0] raddr;
    } ks_cmd_t;

    // Output of the shared slot resolution unit.
    typedef struct packed {
        logic [COUNT_BITS-1:0] slot;
        logic                  oor;
    } slot_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MISS,
        ST_RES_POS,
        ST_RES_NRM,
        ST_RES_TEX,
        ST_DONE
    } state_t;

endpackage

### hw/rtl/vtd_key_store.sv
// Key memory holding one reference triple per table entry.
module vtd_key_store (
    input  logic             clk,
    input  vtd_pkg::ks_cmd_t cmd,
    output vtd_pkg::key_t    rd_data
);
    import vtd_pkg::*;

    key_t mem [TABLE_ENTRIES];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
        if (cmd.re)
        begin
            rd_data <= mem[cmd.raddr];
        end
    end

endmodule

### hw/rtl/vtd_slot_unit.sv
// Shared unit that resolves one attribute reference to a zero-based slot.
module vtd_slot_unit (
    input  logic signed [vtd_pkg::REF_BITS-1:0]   ref_value,
    input  logic        [vtd_pkg::COUNT_BITS-1:0] count,
    output vtd_pkg::slot_res_t                    result
);
    import vtd_pkg::*;

    logic [REF_BITS:0] ref_ext;
    logic [REF_BITS:0] addend;
    logic [REF_BITS:0] sum;
    logic [REF_BITS:0] count_ext;

    // A non-negative reference is 1-based; a negative one counts back from the end.
    assign ref_ext   = {ref_value[REF_BITS-1], ref_value};
    assign count_ext = {{(REF_BITS + 1 - COUNT_BITS){1'b0}}, count};
    assign addend    = ref_value[REF_BITS-1] ? count_ext : {(REF_BITS + 1){1'b1}};
    assign sum       = ref_ext + addend;

    // A negative sum reads as a huge unsigned value, so one compare covers both bounds.
    assign result.oor  = (sum >= count_ext);
    assign result.slot = sum[COUNT_BITS-1:0];

endmodule

### hw/rtl/vertex_triple_deduplicator.sv
// One item at a time: the next word is taken in the cycle after the result is loaded. The
// scan reads one stored triple per cycle; on a miss into a table that is not full, one
// shared adder then resolves the three slots in turn.
// Reset empties the table at once through the fill count and zeroes the three counts.
`include "vertex_triple_deduplicator_macros.svh"

module vertex_triple_deduplicator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input stream: clear_first, position_ref, normal_ref, texcoord_ref, zero pad.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [vtd_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
    // Result stream: vertex_index, is_new, table_full, position_slot, normal_present,
    // normal_slot, texcoord_present, texcoord_slot, slot_out_of_range, zero pad.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [vtd_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
    // Configuration write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vtd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [vtd_pkg::COUNT_BITS-1:0]        cfg_data
);
    import vtd_pkg::*;

    state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] pos_count_reg;
    logic [COUNT_BITS-1:0] nrm_count_reg;
    logic [COUNT_BITS-1:0] tex_count_reg;

    in_word_t              in_word;
    key_t                  key_reg;
    logic [FILL_BITS-1:0]  fill_reg;
    logic [FILL_BITS-1:0]  scan_addr_reg;
    logic [ADDR_BITS-1:0]  rd_addr_reg;
    logic                  rd_pending_reg;
    result_t               res_reg;
    result_t               out_reg;
    logic                  out_valid_reg;

    ks_cmd_t               ram_cmd;
    key_t                  rd_data;
    logic                  in_accept;
    logic                  hit;
    logic                  more;
    logic                  full;
    logic                  load_out;

    logic signed [REF_BITS-1:0] unit_ref;
    logic [COUNT_BITS-1:0]      unit_count;
    slot_res_t                  unit_res;
    logic                       ref_present;

    vtd_key_store u_key_store (
        .clk     (clk),
        .cmd     (ram_cmd),
        .rd_data (rd_data)
    );

    vtd_slot_unit u_slot_unit (
        .ref_value (unit_ref),
        .count     (unit_count),
        .result    (unit_res)
    );

    assign in_word   = in_word_t'(s_axis_tdata[IN_WORD_BITS-1:0]);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign hit       = rd_pending_reg && (rd_data == key_reg);
    assign more      = (scan_addr_reg < fill_reg);
    assign full      = (fill_reg == FILL_BITS'(TABLE_ENTRIES));

    // Operand selection for the shared slot unit.
    always_comb
    begin
        case (state_reg)
            ST_RES_NRM:
            begin
                unit_ref   = key_reg.normal_key;
                unit_count = nrm_count_reg;
            end
            ST_RES_TEX:
            begin
                unit_ref   = key_reg.texcoord_key;
                unit_count = tex_count_reg;
            end
            default:
            begin
                unit_ref   = key_reg.position_key;
                unit_count = pos_count_reg;
            end
        endcase
    end

    assign ref_present = (unit_ref != '0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = ST_DONE;
                end
                else if (!more && !rd_pending_reg)
                begin
                    state_next = ST_MISS;
                end
            end
            ST_MISS:
            begin
                state_next = full ? ST_DONE : ST_RES_POS;
            end
            ST_RES_POS:
            begin
                state_next = ST_RES_NRM;
            end
            ST_RES_NRM:
            begin
                state_next = ST_RES_TEX;
            end
            ST_RES_TEX:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        ram_cmd.we    = 1'b0;
        ram_cmd.waddr = fill_reg[ADDR_BITS-1:0];
        ram_cmd.wdata = key_reg;
        ram_cmd.re    = 1'b0;
        ram_cmd.raddr = scan_addr_reg[ADDR_BITS-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_SCAN:
            begin
                ram_cmd.re = !hit && more;
            end
            ST_MISS:
            begin
                ram_cmd.we = !full;
            end
            ST_DONE:
            begin
                load_out = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pos_count_reg  <= '0;
            nrm_count_reg  <= '0;
            tex_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_pending_reg <= ram_cmd.re;

            if (in_accept && in_word.clear_first)
            begin
                fill_reg <= '0;
            end
            else if (ram_cmd.we)
            begin
                fill_reg <= fill_reg + 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_POSITION_COUNT: pos_count_reg <= cfg_data;
                    CFG_NORMAL_COUNT:   nrm_count_reg <= cfg_data;
                    CFG_TEXCOORD_COUNT: tex_count_reg <= cfg_data;
                    default:            pos_count_reg <= pos_count_reg;
                endcase
            end
        end
    end

    // Payload registers: key, scan pointer, read address, the result being built and the output word.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            key_reg.position_key <= in_word.position_ref;
            key_reg.normal_key   <= in_word.normal_ref;
            key_reg.texcoord_key <= in_word.texcoord_ref;
            scan_addr_reg        <= '0;
            res_reg              <= '0;
        end
        if (ram_cmd.re)
        begin
            scan_addr_reg <= scan_addr_reg + 1'b1;
            rd_addr_reg   <= scan_addr_reg[ADDR_BITS-1:0];
        end
        case (state_reg)
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_reg.vertex_index <= INDEX_BITS'(rd_addr_reg);
                end
            end
            ST_MISS:
            begin
                if (full)
                begin
                    res_reg.table_full <= 1'b1;
                end
                else
                begin
                    res_reg.vertex_index <= fill_reg[INDEX_BITS-1:0];
                    res_reg.is_new       <= 1'b1;
                end
            end
            ST_RES_POS:
            begin
                res_reg.position_slot     <= unit_res.slot;
                res_reg.slot_out_of_range <= unit_res.oor;
            end
            ST_RES_NRM:
            begin
                if (ref_present)
                begin
                    res_reg.normal_present    <= 1'b1;
                    res_reg.normal_slot       <= unit_res.slot;
                    res_reg.slot_out_of_range <= res_reg.slot_out_of_range | unit_res.oor;
                end
            end
            ST_RES_TEX:
            begin
                if (ref_present)
                begin
                    res_reg.texcoord_present  <= 1'b1;
                    res_reg.texcoord_slot     <= unit_res.slot;
                    res_reg.slot_out_of_range <= res_reg.slot_out_of_range | unit_res.oor;
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, out_reg};

    // The fill count never passes the table size.
    `VTD_ASSERT_ALWAYS(a_fill_bound, fill_reg <= FILL_BITS'(TABLE_ENTRIES), "fill count overflow")
    // The scan reads only entries that have been written.
    `VTD_ASSERT_IMPL(a_read_filled, ram_cmd.re, scan_addr_reg < fill_reg, "read of unfilled entry")
    // Every insertion advances the fill count by one.
    `VTD_ASSERT_NEXT(a_fill_step, ram_cmd.we, fill_reg == $past(fill_reg) + 1'b1, "fill step")
    // A delivered word is never both new and a full-table report.
    `VTD_ASSERT_IMPL(a_new_xor_full, m_axis_tvalid, !(out_reg.is_new && out_reg.table_full), "new and full")

endmodule

### verif/vertex_dedup_checker.sv
`timescale 1ns / 100ps
// Checker for the vertex triple deduplicator: predicts every result word and compares it.
module vertex_dedup_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    // clear_first, position_ref, normal_ref, texcoord_ref, zero pad.
    input  logic [vtd_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // vertex_index, is_new, table_full, position_slot, normal_present, normal_slot,
    // texcoord_present, texcoord_slot, slot_out_of_range, zero pad.
    input  logic [vtd_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [vtd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [vtd_pkg::COUNT_BITS-1:0]     cfg_data,
    output int                                 mismatches,
    output int                                 outstanding
);
    import vtd_pkg::*;

    // Loaded attribute counts as last written.
    logic [COUNT_BITS-1:0]   position_count;
    logic [COUNT_BITS-1:0]   normal_count;
    logic [COUNT_BITS-1:0]   texcoord_count;

    // Triples of the current model in order of first appearance; the array index is the vertex index.
    logic [3*REF_BITS-1:0]   stored_triple [TABLE_ENTRIES];
    int                      fill_count;

    result_t                 expected_results [$];
    int                      mismatch_count      = 0;
    int                      results_outstanding = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = results_outstanding;

    // Turns a mesh-file reference into a zero-based slot and flags it against the count.
    function automatic slot_res_t resolve_slot(input logic signed [REF_BITS-1:0] ref_v,
                                               input logic [COUNT_BITS-1:0]     count);
        slot_res_t res;
        longint    resolved;
        if (ref_v >= 0)
            resolved = longint'(ref_v) - 1;
        else
            resolved = longint'(count) + longint'(ref_v);
        res.slot = resolved[COUNT_BITS-1:0];
        res.oor  = (resolved < 0) || (resolved >= longint'(count));
        return res;
    endfunction

    // Looks the corner up, inserts it when new and builds the result word it must produce.
    function automatic result_t dedup_corner(input in_word_t corner);
        result_t               r;
        logic [3*REF_BITS-1:0] key;
        slot_res_t             pos_res;
        slot_res_t             nrm_res;
        slot_res_t             tex_res;
        r = '0;
        if (corner.clear_first)
            fill_count = 0;
        key = {corner.texcoord_ref, corner.normal_ref, corner.position_ref};

        for (int i = 0; i < fill_count; i++)
        begin
            if (stored_triple[i] == key)
            begin
                r.vertex_index = i[INDEX_BITS-1:0];
                return r;
            end
        end

        if (fill_count >= TABLE_ENTRIES)
        begin
            r.table_full = 1'b1;
            return r;
        end

        stored_triple[fill_count] = key;
        r.vertex_index = fill_count[INDEX_BITS-1:0];
        fill_count++;
        r.is_new = 1'b1;

        pos_res = resolve_slot($signed(corner.position_ref), position_count);
        nrm_res = '0;
        tex_res = '0;
        r.position_slot = pos_res.slot;
        if (corner.normal_ref != '0)
        begin
            nrm_res            = resolve_slot($signed(corner.normal_ref), normal_count);
            r.normal_present   = 1'b1;
            r.normal_slot      = nrm_res.slot;
        end
        if (corner.texcoord_ref != '0)
        begin
            tex_res            = resolve_slot($signed(corner.texcoord_ref), texcoord_count);
            r.texcoord_present = 1'b1;
            r.texcoord_slot    = tex_res.slot;
        end
        r.slot_out_of_range = pos_res.oor | nrm_res.oor | tex_res.oor;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, expected, actual);
            mismatch_count++;
        end
    endtask

    // Results are checked before new corners are predicted, so a word that arrives
    // with nothing pending is always caught.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            position_count = '0;
            normal_count   = '0;
            texcoord_count = '0;
            fill_count     = 0;
            expected_results.delete();
            results_outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_POSITION_COUNT: position_count = cfg_data;
                    CFG_NORMAL_COUNT:   normal_count   = cfg_data;
                    CFG_TEXCOORD_COUNT: texcoord_count = cfg_data;
                    default:            ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[OUT_WORD_BITS-1:0]);
                if (expected_results.size() == 0)
                begin
                    $error("result word arrived with nothing expected: 0x%0h", got);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("vertex_index", want.vertex_index, got.vertex_index);
                    check_field("is_new", want.is_new, got.is_new);
                    check_field("table_full", want.table_full, got.table_full);
                    check_field("position_slot", want.position_slot, got.position_slot);
                    check_field("normal_present", want.normal_present, got.normal_present);
                    check_field("normal_slot", want.normal_slot, got.normal_slot);
                    check_field("texcoord_present", want.texcoord_present,
                                got.texcoord_present);
                    check_field("texcoord_slot", want.texcoord_slot, got.texcoord_slot);
                    check_field("slot_out_of_range", want.slot_out_of_range,
                                got.slot_out_of_range);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                expected_results.insert(expected_results.size(),
                    dedup_corner(in_word_t'(s_axis_tdata[IN_WORD_BITS-1:0])));

            results_outstanding = expected_results.size();
        end
    end

endmodule

### verif/vertex_triple_deduplicator_tb.sv
`timescale 1ns / 100ps
// Testbench top for the vertex triple deduplicator: stimulus, idling and the verdict.
module vertex_triple_deduplicator_tb;
    import vtd_pkg::*;

    localparam int     RANDOM_CORNERS = 1350;
    localparam int     POOL_DEPTH     = 160;
    // Filling the whole table dominates the run: each insert scans every entry before it.
    localparam longint TIMEOUT_NS     = 64'd160_000_000;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // clear_first, position_ref, normal_ref, texcoord_ref, zero pad.
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // vertex_index, is_new, table_full, position_slot, normal_present, normal_slot,
    // texcoord_present, texcoord_slot, slot_out_of_range, zero pad.
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index     = '0;
    logic [COUNT_BITS-1:0]     cfg_data      = '0;

    int                        mismatches;
    int                        outstanding;
    int                        send_idle_pct = 0;
    int                        recv_idle_pct = 0;
    int                        pos_cnt       = 0;
    int                        nrm_cnt       = 0;
    int                        tex_cnt       = 0;

    // Triples that a model keeps coming back to.
    logic [REF_BITS-1:0]       pos_pool [POOL_DEPTH];
    logic [REF_BITS-1:0]       nrm_pool [POOL_DEPTH];
    logic [REF_BITS-1:0]       tex_pool [POOL_DEPTH];

    vertex_triple_deduplicator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    vertex_dedup_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always #2 clk = ~clk;

    // Result side back-pressure.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Mixes in-range, boundary, absent and arbitrary references for one attribute.
    function automatic logic [REF_BITS-1:0] pick_ref(input int count, input int zero_pct);
        int roll;
        int span;
        roll = $urandom_range(0, 99);
        span = (count > 0) ? count : 8;
        if (roll < zero_pct)
            return '0;
        if (roll < 45)
            return REF_BITS'($urandom_range(1, span));
        if (roll < 70)
            return REF_BITS'(-int'($urandom_range(1, span)));
        if (roll < 85)
        begin
            case ($urandom_range(0, 3))
                0:       return REF_BITS'(count);
                1:       return REF_BITS'(count + 1);
                2:       return REF_BITS'(-count);
                default: return REF_BITS'(-count - 1);
            endcase
        end
        return REF_BITS'($urandom);
    endfunction

    // Holds cfg_valid high until the register takes the word.
    task automatic write_count(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        cfg_index <= idx;
        cfg_data  <= value[COUNT_BITS-1:0];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Lets the block drain, then loads all three counts.
    task automatic apply_counts(input int p, input int n, input int t);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        write_count(CFG_POSITION_COUNT, p);
        write_count(CFG_NORMAL_COUNT, n);
        write_count(CFG_TEXCOORD_COUNT, t);
        cfg_valid <= 1'b0;
        pos_cnt = p;
        nrm_cnt = n;
        tex_cnt = t;
    endtask

    // Presents one corner word after a random gap; tvalid stays high for the next one.
    task automatic send_corner(input logic clear, input logic [REF_BITS-1:0] p,
                               input logic [REF_BITS-1:0] n, input logic [REF_BITS-1:0] t);
        in_word_t corner;
        corner.clear_first  = clear;
        corner.position_ref = p;
        corner.normal_ref   = n;
        corner.texcoord_ref = t;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  <= {{(IN_TDATA_BITS - IN_WORD_BITS){1'b0}}, corner};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Models that reuse a small pool of triples, with stray triples and early clears.
    task automatic run_models(input int corners);
        int                  sent;
        int                  model_len;
        int                  pool_size;
        int                  pick;
        logic                clear;
        logic [REF_BITS-1:0] p;
        logic [REF_BITS-1:0] n;
        logic [REF_BITS-1:0] t;
        sent = 0;
        while (sent < corners)
        begin
            if ($urandom_range(0, 19) == 0)
                model_len = $urandom_range(100, 300);
            else
                model_len = $urandom_range(2, 40);
            pool_size = $urandom_range(1, model_len / 2 + 1);
            for (int k = 0; k < pool_size; k++)
            begin
                pos_pool[k] = pick_ref(pos_cnt, 3);
                nrm_pool[k] = pick_ref(nrm_cnt, 25);
                tex_pool[k] = pick_ref(tex_cnt, 25);
            end
            for (int k = 0; k < model_len && sent < corners; k++)
            begin
                clear = (k == 0) || ($urandom_range(0, 49) == 0);
                if ($urandom_range(0, 99) < 85)
                begin
                    pick = $urandom_range(0, pool_size - 1);
                    p    = pos_pool[pick];
                    n    = nrm_pool[pick];
                    t    = tex_pool[pick];
                end
                else
                begin
                    p = pick_ref(pos_cnt, 3);
                    n = pick_ref(nrm_cnt, 25);
                    t = pick_ref(tex_cnt, 25);
                end
                send_corner(clear, p, n, t);
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [REF_BITS-1:0] first_nrm;
        logic [REF_BITS-1:0] first_tex;
        logic [REF_BITS-1:0] last_nrm;
        logic [REF_BITS-1:0] last_tex;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corners: repeats, absent attributes, every out-of-range flavor,
        // reference extremes, one-field differences and clearing.
        send_idle_pct = 30;
        recv_idle_pct = 54;
        apply_counts(10, 5, 7);
        send_corner(1'b1, 1, 1, 1);
        send_corner(1'b0, 1, 1, 1);
        send_corner(1'b0, 1, 0, 0);
        send_corner(1'b0, -1, -1, -1);
        send_corner(1'b0, 0, 2, 3);
        send_corner(1'b0, 11, 1, 1);
        send_corner(1'b0, -11, 1, 1);
        send_corner(1'b0, 1, 6, 1);
        send_corner(1'b0, 1, 1, 8);
        send_corner(1'b0, 1, -6, -8);
        send_corner(1'b0, 8388607, 8388607, 8388607);
        send_corner(1'b0, -8388608, -8388608, -8388608);
        send_corner(1'b0, 1, 1, 2);
        send_corner(1'b0, 1, 2, 1);
        send_corner(1'b0, 2, 1, 1);
        send_corner(1'b0, -1, -1, -1);
        send_corner(1'b0, 1, 0, 0);
        send_corner(1'b0, 1, 0, 1);
        send_corner(1'b0, 1, 1, 0);
        send_corner(1'b1, 1, 0, 0);
        send_corner(1'b0, 1, 1, 1);
        send_corner(1'b0, 0, 0, 0);

        // Random models across count settings and idling patterns.
        apply_counts(16, 8, 12);
        run_models(RANDOM_CORNERS / 6);
        apply_counts($urandom_range(0, 8388607), $urandom_range(0, 8388607),
                     $urandom_range(0, 8388607));
        run_models(RANDOM_CORNERS / 6);

        send_idle_pct = 54;
        recv_idle_pct = 30;
        apply_counts(0, 0, 0);
        run_models(RANDOM_CORNERS / 6);
        apply_counts(8388607, 8388607, 8388607);
        run_models(RANDOM_CORNERS / 6);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_counts(1, 1, 1);
        run_models(RANDOM_CORNERS / 6);
        apply_counts($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64));
        run_models(RANDOM_CORNERS / 6);

        // Fill every entry with distinct positions, then probe the full table.
        apply_counts(TABLE_ENTRIES, $urandom_range(1, 8388607), $urandom_range(1, 8388607));
        first_nrm = '0;
        first_tex = '0;
        last_nrm  = '0;
        last_tex  = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            last_nrm = pick_ref(nrm_cnt, 25);
            last_tex = pick_ref(tex_cnt, 25);
            if (i == 0)
            begin
                first_nrm = last_nrm;
                first_tex = last_tex;
            end
            send_corner(i == 0, REF_BITS'(i + 1), last_nrm, last_tex);
        end
        send_corner(1'b0, REF_BITS'(TABLE_ENTRIES + 1), 0, 0);
        send_corner(1'b0, -1, pick_ref(nrm_cnt, 25), pick_ref(tex_cnt, 25));
        send_corner(1'b0, REF_BITS'(TABLE_ENTRIES), last_nrm, last_tex);
        send_corner(1'b0, 1, first_nrm, first_tex);
        send_corner(1'b1, REF_BITS'(TABLE_ENTRIES + 1), 0, 0);

        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (64) @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/vtd_pkg.sv
hw/rtl/vtd_key_store.sv
hw/rtl/vtd_slot_unit.sv
hw/rtl/vertex_triple_deduplicator.sv
verif/vertex_dedup_checker.sv
verif/vertex_triple_deduplicator_tb.sv
